// ----- src/fcre_pkg.sv -----
`timescale 1ns / 1ps

package fcre_pkg;

	localparam int MAX_COLUMNS = 512;
	localparam int MAX_ROWS    = 512;

	localparam int COL_W       = $clog2(MAX_COLUMNS);
	localparam int ROW_W       = $clog2(MAX_ROWS);
	localparam int STORE_DEPTH = MAX_COLUMNS * MAX_ROWS;
	localparam int ADDR_W      = $clog2(STORE_DEPTH);

	localparam int LEVEL_W    = 8;
	localparam int DIM_W      = 10;
	localparam int POS_W      = 9;
	localparam int KIND_W     = 2;
	localparam int CFG_IDX_W  = 2;
	localparam int CFG_DATA_W = 10;

	localparam int CMP_W0 = (COL_W + 1 > DIM_W) ? COL_W + 1 : DIM_W;
	localparam int CMP_W  = (ROW_W + 1 > CMP_W0) ? ROW_W + 1 : CMP_W0;

	localparam int QDEPTH = 16;
	localparam int QPTR_W = $clog2(QDEPTH);
	localparam int QCNT_W = $clog2(QDEPTH + 1);

	localparam logic [CFG_IDX_W-1:0] CFG_THRESHOLD = 2'd0;
	localparam logic [CFG_IDX_W-1:0] CFG_WIDTH     = 2'd1;
	localparam logic [CFG_IDX_W-1:0] CFG_HEIGHT    = 2'd2;

	localparam logic [LEVEL_W-1:0] THRESHOLD_RST = 8'd128;
	localparam logic [DIM_W-1:0]   WIDTH_RST     = 10'd480;
	localparam logic [DIM_W-1:0]   HEIGHT_RST    = 10'd360;

	typedef enum logic [KIND_W-1:0] {
		KIND_RUN_START = 2'd0,
		KIND_RUN_END   = 2'd1,
		KIND_ROW       = 2'd2,
		KIND_FRAME     = 2'd3
	} kind_t;

	// results caused by one pixel
	typedef struct packed {
		logic             has_run;
		logic             run_end;
		logic [COL_W-1:0] col;
		logic             has_row;
		logic [ROW_W-1:0] row;
		logic             has_frame;
	} rgrp_t;

	function automatic logic [CMP_W-1:0] clamp_dim(input logic [DIM_W-1:0] v,
			input logic [CMP_W-1:0] lim);
		logic [CMP_W-1:0] ext;
		ext = CMP_W'(v);
		if (v == '0) begin
			return CMP_W'(1);
		end else if (ext > lim) begin
			return lim;
		end
		return ext;
	endfunction

	function automatic logic [POS_W-1:0] pos_of_col(input logic [COL_W-1:0] c);
		logic [COL_W+POS_W-1:0] t;
		t = {{POS_W{1'b0}}, c};
		return t[POS_W-1:0];
	endfunction

	function automatic logic [POS_W-1:0] pos_of_row(input logic [ROW_W-1:0] r);
		logic [ROW_W+POS_W-1:0] t;
		t = {{POS_W{1'b0}}, r};
		return t[POS_W-1:0];
	endfunction

endpackage

// ----- src/fcre_ram.sv -----
`timescale 1ns / 1ps

module fcre_ram #(
	parameter int WIDTH = 1,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		if (re) begin
			rdata <= mem[raddr];
		end
	end

endmodule

// ----- src/fcre_pixel.sv -----
`timescale 1ns / 1ps

module fcre_pixel (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          in_fire,
	input  logic [fcre_pkg::LEVEL_W-1:0]  intensity,
	input  logic [fcre_pkg::LEVEL_W-1:0]  threshold,
	input  logic [fcre_pkg::DIM_W-1:0]    width,
	input  logic [fcre_pkg::DIM_W-1:0]    height,
	output logic                          busy,
	output logic                          s1_valid,
	output logic                          grp_valid,
	output fcre_pkg::rgrp_t               grp
);

	import fcre_pkg::*;

	logic [COL_W-1:0]   col_q;
	logic [ROW_W-1:0]   row_q;
	logic               run_open_q;
	logic               row_chg_q;
	logic               busy_q;
	logic [ADDR_W-1:0]  clr_addr_q;

	logic               v_s1;
	logic [LEVEL_W-1:0] intensity_s1;
	logic [COL_W-1:0]   col_s1;
	logic [ROW_W-1:0]   row_s1;
	logic               row_end_s1;
	logic               frame_end_s1;
	logic [ADDR_W-1:0]  addr_s1;
	logic               fwd_hit_s1;
	logic               fwd_bit_s1;

	logic [CMP_W-1:0]   w_eff;
	logic [CMP_W-1:0]   h_eff;
	logic               row_end;
	logic               frame_end;
	logic [ADDR_W-1:0]  rd_addr;

	logic               rdata;
	logic               old_level;
	logic               new_level;
	logic               changed;
	logic               row_chg_n;

	logic               ram_we;
	logic [ADDR_W-1:0]  ram_waddr;
	logic               ram_wdata;

	always_comb begin
		w_eff     = clamp_dim(width, CMP_W'(MAX_COLUMNS));
		h_eff     = clamp_dim(height, CMP_W'(MAX_ROWS));
		row_end   = (CMP_W'(col_q) + CMP_W'(1)) >= w_eff;
		frame_end = row_end && ((CMP_W'(row_q) + CMP_W'(1)) >= h_eff);
		rd_addr   = ADDR_W'(row_q) * ADDR_W'(MAX_COLUMNS) + ADDR_W'(col_q);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			col_q <= '0;
			row_q <= '0;
		end else if (in_fire) begin
			if (row_end) begin
				col_q <= '0;
				if (frame_end) begin
					row_q <= '0;
				end else begin
					row_q <= row_q + ROW_W'(1);
				end
			end else begin
				col_q <= col_q + COL_W'(1);
			end
		end
	end

	// store clear after reset
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q     <= 1'b1;
			clr_addr_q <= '0;
		end else if (busy_q) begin
			if (clr_addr_q == ADDR_W'(STORE_DEPTH - 1)) begin
				busy_q <= 1'b0;
			end else begin
				clr_addr_q <= clr_addr_q + ADDR_W'(1);
			end
		end
	end

	always_comb begin
		old_level = fwd_hit_s1 ? fwd_bit_s1 : rdata;
		new_level = old_level;
		if (!old_level && (intensity_s1 > threshold)) begin
			new_level = 1'b1;
		end else if (old_level && (intensity_s1 < threshold)) begin
			new_level = 1'b0;
		end
		changed = new_level != old_level;
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1       <= 1'b0;
			fwd_hit_s1 <= 1'b0;
		end else begin
			v_s1       <= in_fire;
			fwd_hit_s1 <= in_fire && v_s1 && (addr_s1 == rd_addr);
		end
	end

	always_ff @(posedge clk) begin
		if (in_fire) begin
			intensity_s1 <= intensity;
			col_s1       <= col_q;
			row_s1       <= row_q;
			row_end_s1   <= row_end;
			frame_end_s1 <= frame_end;
			addr_s1      <= rd_addr;
			fwd_bit_s1   <= new_level;
		end
	end

	assign ram_we    = busy_q || v_s1;
	assign ram_waddr = busy_q ? clr_addr_q : addr_s1;
	assign ram_wdata = busy_q ? 1'b0 : new_level;

	fcre_ram #(
		.WIDTH (1),
		.DEPTH (STORE_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (ram_we),
		.waddr (ram_waddr),
		.wdata (ram_wdata),
		.re    (in_fire),
		.raddr (rd_addr),
		.rdata (rdata)
	);

	always_comb begin
		row_chg_n     = row_chg_q || changed;
		grp.has_run   = changed ? !run_open_q : run_open_q;
		grp.run_end   = !changed;
		grp.col       = col_s1;
		grp.has_row   = row_end_s1 && row_chg_n;
		grp.row       = row_s1;
		grp.has_frame = frame_end_s1;
		grp_valid     = v_s1 && (grp.has_run || grp.has_row || grp.has_frame);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_open_q <= 1'b0;
			row_chg_q  <= 1'b0;
		end else if (v_s1) begin
			run_open_q <= changed && !row_end_s1;
			row_chg_q  <= row_chg_n && !row_end_s1;
		end
	end

	assign busy     = busy_q;
	assign s1_valid = v_s1;

	a_no_item_in_clear: assert property (@(posedge clk) disable iff (!arst_n)
		busy_q |-> !in_fire)
		else $error("pixel transfer during store clear");

	a_fwd_needs_item: assert property (@(posedge clk) disable iff (!arst_n)
		fwd_hit_s1 |-> v_s1)
		else $error("forward flag without item in stage 1");

	a_row_wrap: assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && row_end) |=> (col_q == '0))
		else $error("column did not wrap at row end");

endmodule

// ----- src/fcre_queue.sv -----
`timescale 1ns / 1ps

module fcre_queue (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        push,
	input  fcre_pkg::rgrp_t             push_grp,
	output logic [fcre_pkg::QCNT_W-1:0] cnt,
	output logic                        out_valid,
	input  logic                        out_stall,
	output logic [fcre_pkg::KIND_W-1:0] kind,
	output logic [fcre_pkg::POS_W-1:0]  position,
	output logic                        last
);

	import fcre_pkg::*;

	rgrp_t              mem_q [QDEPTH];
	logic [QPTR_W-1:0]  wr_ptr_q;
	logic [QPTR_W-1:0]  rd_ptr_q;
	logic [QCNT_W-1:0]  cnt_q;
	logic [2:0]         done_q;

	rgrp_t              head;
	logic [2:0]         present;
	logic [2:0]         pending;
	logic [2:0]         cur;
	logic               pop;
	logic               xfer;
	kind_t              kind_sel;

	always_comb begin
		head      = mem_q[rd_ptr_q];
		present   = {head.has_frame, head.has_row, head.has_run};
		pending   = present & ~done_q;
		cur       = pending & (~pending + 3'd1);
		last      = (pending & ~cur) == 3'b000;
		out_valid = cnt_q != '0;
		xfer      = out_valid && !out_stall;
		pop       = xfer && last;
		if (cur[0]) begin
			kind_sel = head.run_end ? KIND_RUN_END : KIND_RUN_START;
			position = pos_of_col(head.col);
		end else if (cur[1]) begin
			kind_sel = KIND_ROW;
			position = pos_of_row(head.row);
		end else begin
			kind_sel = KIND_FRAME;
			position = '0;
		end
		kind = kind_sel;
	end

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_grp;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			cnt_q    <= '0;
			done_q   <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= (wr_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : wr_ptr_q + QPTR_W'(1);
			end
			if (pop) begin
				rd_ptr_q <= (rd_ptr_q == QPTR_W'(QDEPTH - 1)) ? '0 : rd_ptr_q + QPTR_W'(1);
				done_q   <= '0;
			end else if (xfer) begin
				done_q <= done_q | cur;
			end
			if (push && !pop) begin
				cnt_q <= cnt_q + QCNT_W'(1);
			end else if (pop && !push) begin
				cnt_q <= cnt_q - QCNT_W'(1);
			end
		end
	end

	assign cnt = cnt_q;

	a_no_overflow: assert property (@(posedge clk) disable iff (!arst_n)
		push |-> (cnt_q < QCNT_W'(QDEPTH) || pop))
		else $error("result queue overflow");

	a_head_has_part: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> (pending != 3'b000))
		else $error("queued group has nothing left to send");

	a_done_subset: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid |-> ((done_q & ~present) == 3'b000))
		else $error("sent mask outside the group's results");

endmodule

// ----- src/frame_change_run_encoder_unit.sv -----
`timescale 1ns / 1ps
// Path: a pixel's results pass the stage-1 register and then a result queue entry before they are offered.
// Throughput: one pixel per cycle while in_stall is low; the frame store is read one cycle and written the next.
// Up to three results per pixel drain one per cycle, while out_stall is low, through a 16-group result queue.
// Reset: config returns to 128/480/360 and the store clear of all 262144 entries runs
// (one entry per cycle) with in_stall high; config writes are taken meanwhile.
module frame_change_run_encoder_unit (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            in_valid,
	output logic                            in_stall,
	input  logic [fcre_pkg::LEVEL_W-1:0]    intensity,
	output logic                            out_valid,
	input  logic                            out_stall,
	output logic [fcre_pkg::KIND_W-1:0]     kind,
	output logic [fcre_pkg::POS_W-1:0]      position,
	output logic                            last,
	input  logic                            cfg_we,
	input  logic [fcre_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [fcre_pkg::CFG_DATA_W-1:0] cfg_data
);

	import fcre_pkg::*;

	logic [LEVEL_W-1:0] threshold_q;
	logic [DIM_W-1:0]   width_q;
	logic [DIM_W-1:0]   height_q;

	logic               busy;
	logic               s1_valid;
	logic               grp_valid;
	rgrp_t              grp;
	logic [QCNT_W-1:0]  cnt;
	logic               in_fire;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			threshold_q <= THRESHOLD_RST;
			width_q     <= WIDTH_RST;
			height_q    <= HEIGHT_RST;
		end else if (cfg_we) begin
			unique case (cfg_index)
				CFG_THRESHOLD: threshold_q <= cfg_data[LEVEL_W-1:0];
				CFG_WIDTH:     width_q     <= cfg_data[DIM_W-1:0];
				CFG_HEIGHT:    height_q    <= cfg_data[DIM_W-1:0];
				default: ;
			endcase
		end
	end

	// room for the group in stage 1 plus the one entering
	assign in_stall = busy || ((QCNT_W + 1)'(cnt) + (QCNT_W + 1)'(s1_valid)
		>= (QCNT_W + 1)'(QDEPTH));
	assign in_fire  = in_valid && !in_stall;

	fcre_pixel u_pixel (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_fire   (in_fire),
		.intensity (intensity),
		.threshold (threshold_q),
		.width     (width_q),
		.height    (height_q),
		.busy      (busy),
		.s1_valid  (s1_valid),
		.grp_valid (grp_valid),
		.grp       (grp)
	);

	fcre_queue u_queue (
		.clk       (clk),
		.arst_n    (arst_n),
		.push      (grp_valid),
		.push_grp  (grp),
		.cnt       (cnt),
		.out_valid (out_valid),
		.out_stall (out_stall),
		.kind      (kind),
		.position  (position),
		.last      (last)
	);

endmodule

// ----- dv/tb_frame_change_run_encoder_unit.sv -----
`timescale 1ns / 1ps

module tb_frame_change_run_encoder_unit;
	import fcre_pkg::*;

	localparam int CYCLE_LIMIT   = 2_000_000;
	localparam int SETTLE_CYCLES = 8;

	typedef struct {
		kind_t            kind;
		logic [POS_W-1:0] position;
		logic             last;
	} change_event_t;

	logic                  clk = 1'b0;
	logic                  arst_n;
	logic                  in_valid;
	logic                  in_stall;
	logic [LEVEL_W-1:0]    intensity;
	logic                  out_valid;
	logic                  out_stall = 1'b0;
	logic [KIND_W-1:0]     kind;
	logic [POS_W-1:0]      position;
	logic                  last;
	logic                  cfg_we;
	logic [CFG_IDX_W-1:0]  cfg_index;
	logic [CFG_DATA_W-1:0] cfg_data;

	// shadow of the block: stored levels, scan position, run state, registers
	bit                 level_map [STORE_DEPTH];
	int                 col_pos;
	int                 row_pos;
	bit                 run_active;
	bit                 row_changed;
	logic [LEVEL_W-1:0] thr_shadow    = THRESHOLD_RST;
	logic [DIM_W-1:0]   width_shadow  = WIDTH_RST;
	logic [DIM_W-1:0]   height_shadow = HEIGHT_RST;

	change_event_t pending_events[$];
	int            src_idle_pct;
	int            snk_stall_pct;
	int            pixels_sent;
	int            events_seen;
	int            mismatches;
	int            settings_applied;
	int            cycles;

	frame_change_run_encoder_unit u_top (.*);

	always begin
		#1 clk = 1'b1;
		#1 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		if (cycles == CYCLE_LIMIT) begin
			$display("timeout after %0d cycles, %0d results outstanding", cycles,
				pending_events.size());
			$display("FAILURE");
			$finish;
		end
	end

	always @(posedge clk) begin
		out_stall <= ($urandom_range(99) < snk_stall_pct);
	end

	function automatic int clip_dim(input logic [DIM_W-1:0] v, input int lim);
		if (v == '0) begin
			return 1;
		end
		if (int'(v) > lim) begin
			return lim;
		end
		return int'(v);
	endfunction

	// advance the shadow by one pixel and queue the results it causes
	function automatic void predict_pixel(input logic [LEVEL_W-1:0] v);
		change_event_t evs[$];
		change_event_t ev;
		int w;
		int h;
		int addr;
		bit flipped;
		w = clip_dim(width_shadow, MAX_COLUMNS);
		h = clip_dim(height_shadow, MAX_ROWS);
		addr = (row_pos * MAX_COLUMNS + col_pos) % STORE_DEPTH;
		flipped = 1'b0;
		ev.last = 1'b0;
		if (!level_map[addr] && v > thr_shadow) begin
			level_map[addr] = 1'b1;
			flipped = 1'b1;
		end else if (level_map[addr] && v < thr_shadow) begin
			level_map[addr] = 1'b0;
			flipped = 1'b1;
		end
		if (flipped) begin
			if (!run_active) begin
				ev.kind = KIND_RUN_START;
				ev.position = POS_W'(col_pos);
				evs.push_back(ev);
				run_active = 1'b1;
			end
			row_changed = 1'b1;
		end else if (run_active) begin
			ev.kind = KIND_RUN_END;
			ev.position = POS_W'(col_pos);
			evs.push_back(ev);
			run_active = 1'b0;
		end
		if (col_pos + 1 >= w) begin
			if (row_changed) begin
				ev.kind = KIND_ROW;
				ev.position = POS_W'(row_pos);
				evs.push_back(ev);
			end
			// an open run is dropped at row end, never closed
			run_active = 1'b0;
			row_changed = 1'b0;
			col_pos = 0;
			if (row_pos + 1 >= h) begin
				ev.kind = KIND_FRAME;
				ev.position = '0;
				evs.push_back(ev);
				row_pos = 0;
			end else begin
				row_pos++;
			end
		end else begin
			col_pos++;
		end
		if (evs.size() > 0) begin
			ev = evs.pop_back();
			ev.last = 1'b1;
			evs.push_back(ev);
		end
		foreach (evs[i]) begin
			pending_events.push_back(evs[i]);
		end
	endfunction

	function automatic logic [LEVEL_W-1:0] pick_intensity();
		int unsigned sel;
		sel = $urandom_range(9);
		if (sel < 4) begin
			if (thr_shadow == 8'hFF) begin
				return 8'hFF;
			end
			return LEVEL_W'($urandom_range(255, thr_shadow + 1));
		end
		if (sel < 8) begin
			if (thr_shadow == 8'h00) begin
				return 8'h00;
			end
			return LEVEL_W'($urandom_range(thr_shadow - 1, 0));
		end
		if (sel == 8) begin
			return thr_shadow;
		end
		return LEVEL_W'($urandom_range(255));
	endfunction

	task automatic push_pixel(input logic [LEVEL_W-1:0] v);
		while ($urandom_range(99) < src_idle_pct) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		intensity <= v;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		predict_pixel(v);
		pixels_sent++;
	endtask

	// drain, then write all three registers back to back
	task automatic apply_setting(input logic [LEVEL_W-1:0] thr, input logic [DIM_W-1:0] w,
			input logic [DIM_W-1:0] h);
		in_valid <= 1'b0;
		@(posedge clk);
		while (pending_events.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we <= 1'b1;
		cfg_index <= CFG_THRESHOLD;
		cfg_data <= {(CFG_DATA_W - LEVEL_W)'($urandom), thr};
		@(posedge clk);
		cfg_index <= CFG_WIDTH;
		cfg_data <= CFG_DATA_W'(w);
		@(posedge clk);
		cfg_index <= CFG_HEIGHT;
		cfg_data <= CFG_DATA_W'(h);
		@(posedge clk);
		cfg_we <= 1'b0;
		thr_shadow = thr;
		width_shadow = w;
		height_shadow = h;
		settings_applied++;
	endtask

	always @(posedge clk) begin
		change_event_t want;
		if (arst_n && out_valid && !out_stall) begin
			events_seen++;
			if (pending_events.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) begin
					$display("unexpected transfer %0d: kind %0d position %0d last %0d",
						events_seen, kind, position, last);
				end
			end else begin
				want = pending_events.pop_front();
				if (kind !== want.kind || position !== want.position || last !== want.last) begin
					mismatches++;
					if (mismatches <= 10) begin
						$display("transfer %0d: expected kind %0d position %0d last %0d",
							events_seen, want.kind, want.position, want.last);
						$display("transfer %0d:      got kind %0d position %0d last %0d",
							events_seen, kind, position, last);
					end
				end
			end
		end
	end

	task automatic test_default_settings();
		push_pixel(8'd255);
		push_pixel(8'd255);
		push_pixel(8'd128);
		push_pixel(8'd0);
		push_pixel(8'd200);
		push_pixel(8'd127);
		push_pixel(8'd129);
		push_pixel(8'd0);
	endtask

	task automatic test_threshold_extremes();
		apply_setting(8'd0, 10'd4, 10'd2);
		push_pixel(8'd0);
		push_pixel(8'd1);
		push_pixel(8'd0);
		push_pixel(8'd255);
		push_pixel(8'd255);
		push_pixel(8'd0);
		push_pixel(8'd0);
		push_pixel(8'd128);
		apply_setting(8'd255, 10'd4, 10'd2);
		push_pixel(8'd255);
		push_pixel(8'd254);
		push_pixel(8'd0);
		push_pixel(8'd255);
		push_pixel(8'd0);
		push_pixel(8'd0);
		push_pixel(8'd255);
		push_pixel(8'd254);
	endtask

	task automatic test_open_run_row_end();
		apply_setting(8'd128, 10'd3, 10'd2);
		push_pixel(8'd0);
		push_pixel(8'd0);
		push_pixel(8'd255);
		push_pixel(8'd255);
		push_pixel(8'd255);
		push_pixel(8'd255);
		push_pixel(8'd0);
		push_pixel(8'd0);
		push_pixel(8'd0);
	endtask

	task automatic test_zero_size_frame();
		apply_setting(8'd128, 10'd0, 10'd0);
		push_pixel(8'd255);
		push_pixel(8'd0);
		push_pixel(8'd128);
		push_pixel(8'd0);
	endtask

	task automatic test_shrink_mid_frame();
		apply_setting(8'd100, 10'd8, 10'd4);
		repeat (13) push_pixel(pick_intensity());
		apply_setting(8'd100, 10'd3, 10'd1);
		repeat (3) push_pixel(pick_intensity());
		apply_setting(8'd100, 10'd8, 10'd4);
		repeat (20) push_pixel(pick_intensity());
		apply_setting(8'd100, 10'd8, 10'd2);
		repeat (8) push_pixel(pick_intensity());
	endtask

	task automatic test_oversize_dims();
		apply_setting(LEVEL_W'($urandom_range(255)), 10'h3FF, 10'h3FF);
		repeat (16) push_pixel(pick_intensity());
	endtask

	task automatic test_random_traffic(input int src_pct, input int snk_pct, input int count);
		logic [LEVEL_W-1:0] thr;
		int unsigned sel;
		src_idle_pct = src_pct;
		snk_stall_pct = snk_pct;
		for (int seg = 0; seg < 2; seg++) begin
			sel = $urandom_range(4);
			if (sel == 0) begin
				thr = 8'd0;
			end else if (sel == 1) begin
				thr = 8'd255;
			end else begin
				thr = LEVEL_W'($urandom_range(255));
			end
			apply_setting(thr, DIM_W'($urandom_range(12)), DIM_W'($urandom_range(5)));
			repeat (count / 2) push_pixel(pick_intensity());
		end
	endtask

	initial begin
		arst_n <= 1'b0;
		in_valid <= 1'b0;
		intensity <= '0;
		cfg_we <= 1'b0;
		cfg_index <= CFG_THRESHOLD;
		cfg_data <= '0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;

		test_default_settings();
		test_threshold_extremes();
		test_open_run_row_end();
		test_zero_size_frame();
		test_shrink_mid_frame();
		test_oversize_dims();
		test_random_traffic(0, 0, 44);
		test_random_traffic(87, 0, 44);
		test_random_traffic(0, 87, 44);
		test_random_traffic(10, 10, 44);

		in_valid <= 1'b0;
		while (pending_events.size() != 0) begin
			@(posedge clk);
		end
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Checked %0d results from %0d pixels over %0d register settings.",
			events_seen, pixels_sent, settings_applied);
		$display("Covered threshold and size extremes, oversized sizes, mid-frame resizing,");
		$display("and input gaps and output stalls on both sides.");
		if (mismatches == 0 && pending_events.size() == 0) begin
			$display("SUCCESS");
		end else begin
			$display("%0d mismatches", mismatches);
			$display("FAILURE");
		end
		$finish;
	end

endmodule

// ----- files.f -----
src/fcre_pkg.sv
src/fcre_ram.sv
src/fcre_pixel.sv
src/fcre_queue.sv
src/frame_change_run_encoder_unit.sv
dv/tb_frame_change_run_encoder_unit.sv
